[sv/lws_pkg.sv]
// Shared types and constants for the windowed latency statistics block.
// Depends on nothing; every other file of the block imports it.
package lws_pkg;

	localparam int TIME_W      = 48;
	localparam int COUNT_W     = 32;
	localparam int SUM_W       = 64;
	localparam int ROUND_W     = 16;
	localparam int PAY_W       = 32;
	localparam int NUM_METRICS = 4;
	localparam int METRIC_W    = 2;
	localparam int APB_DATA_W  = 64;
	localparam int APB_ADDR_W  = 4;

	// register map: register index is paddr[3]
	localparam logic REG_ROUND_DURATION = 1'b0;
	localparam logic [TIME_W-1:0] ROUND_DURATION_RESET = TIME_W'(1000000000);

	// metric codes
	localparam logic [METRIC_W-1:0] MET_EXEC    = 2'd0;
	localparam logic [METRIC_W-1:0] MET_LATENCY = 2'd1;
	localparam logic [METRIC_W-1:0] MET_PAYLOAD = 2'd2;
	localparam logic [METRIC_W-1:0] MET_FULL    = 2'd3;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_FLUSH  = 1'b1
	} op_t;

	// one request on the input channel
	typedef struct packed {
		op_t                operation;
		logic [TIME_W-1:0]  received_time;
		logic [TIME_W-1:0]  service_start;
		logic [TIME_W-1:0]  service_end;
		logic [PAY_W-1:0]   payload_bytes;
	} req_t;

	// one summary on the output channel
	typedef struct packed {
		logic [METRIC_W-1:0] metric;
		logic [ROUND_W-1:0]  round_number;
		logic [COUNT_W-1:0]  sample_count;
		logic [TIME_W-1:0]   minimum;
		logic [TIME_W-1:0]   maximum;
		logic [SUM_W-1:0]    sum;
		logic                last;
	} res_t;

	// input stage: operation, receive time and the four formed metrics
	typedef struct packed {
		op_t                               op;
		logic [TIME_W-1:0]                 rx;
		logic [NUM_METRICS-1:0][TIME_W-1:0] val;
	} stage_t;

	// snapshot of a closed round
	typedef struct packed {
		logic [ROUND_W-1:0]                 round_number;
		logic [COUNT_W-1:0]                 count;
		logic [NUM_METRICS-1:0][TIME_W-1:0] min;
		logic [NUM_METRICS-1:0][TIME_W-1:0] max;
		logic [NUM_METRICS-1:0][SUM_W-1:0]  sum;
	} summary_t;

endpackage

[sv/lws_ingress.sv]
// Input register: takes a request and forms the four clamped metrics.
// Depends on lws_pkg.
module lws_ingress (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lws_pkg::req_t   in_data,
	input  logic            adv,
	output logic            valid_s1,
	output lws_pkg::stage_t data_s1
);
	import lws_pkg::*;

	stage_t form;

	// form metrics, clamping negative differences to zero
	always_comb begin
		form.op = in_data.operation;
		form.rx = in_data.received_time;
		form.val[MET_EXEC] = (in_data.service_end >= in_data.service_start) ?
			in_data.service_end - in_data.service_start : '0;
		form.val[MET_LATENCY] = (in_data.service_start >= in_data.received_time) ?
			in_data.service_start - in_data.received_time : '0;
		form.val[MET_PAYLOAD] = TIME_W'(in_data.payload_bytes);
		form.val[MET_FULL] = (in_data.service_end >= in_data.received_time) ?
			in_data.service_end - in_data.received_time : '0;
	end

	assign in_ready = !valid_s1 || adv;

	// hold the stage until the round tracker consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= form;
		end
	end

endmodule

[sv/lws_round.sv]
// Round tracker: window check, count, per-metric min, max and sum, round close.
// Depends on lws_pkg.
module lws_round (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	input  lws_pkg::stage_t             data_s1,
	input  logic [lws_pkg::TIME_W-1:0]  round_duration,
	input  logic                        snap_free,
	output logic                        adv,
	output logic                        snap_load,
	output lws_pkg::summary_t           snap
);
	import lws_pkg::*;

	logic                               active_q;
	logic [TIME_W-1:0]                  start_q;
	logic [ROUND_W-1:0]                 index_q;
	logic [COUNT_W-1:0]                 count_q;
	logic [NUM_METRICS-1:0][TIME_W-1:0] min_q;
	logic [NUM_METRICS-1:0][TIME_W-1:0] max_q;
	logic [NUM_METRICS-1:0][SUM_W-1:0]  sum_q;

	logic              is_flush;
	logic              in_window;
	logic              closes;
	logic [TIME_W-1:0] offset;

	// decide whether the request belongs to the open round
	always_comb begin
		is_flush  = (data_s1.op == OP_FLUSH);
		offset    = data_s1.rx - start_q;
		in_window = active_q && (data_s1.rx >= start_q) && (offset < round_duration);
		closes    = active_q && (is_flush || !in_window);
		adv       = valid_s1 && (!closes || snap_free);
		snap_load = adv && closes;
	end

	assign snap.round_number = index_q;
	assign snap.count        = count_q;
	assign snap.min          = min_q;
	assign snap.max          = max_q;
	assign snap.sum          = sum_q;

	// control state: open flag, round index, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			index_q  <= '0;
			count_q  <= '0;
		end else if (adv) begin
			if (closes) begin
				index_q <= index_q + 1'b1;
			end
			if (is_flush) begin
				active_q <= 1'b0;
			end else if (in_window) begin
				if (!(&count_q)) begin
					count_q <= count_q + 1'b1;
				end
			end else begin
				active_q <= 1'b1;
				count_q  <= COUNT_W'(1);
			end
		end
	end

	// accumulate or open a fresh round at the request's receive time
	always_ff @(posedge clk) begin
		if (adv && !is_flush) begin
			if (in_window) begin
				for (int m = 0; m < NUM_METRICS; m++) begin
					if (data_s1.val[m] < min_q[m]) min_q[m] <= data_s1.val[m];
					if (data_s1.val[m] > max_q[m]) max_q[m] <= data_s1.val[m];
					sum_q[m] <= sum_q[m] + SUM_W'(data_s1.val[m]);
				end
			end else begin
				start_q <= data_s1.rx;
				for (int m = 0; m < NUM_METRICS; m++) begin
					min_q[m] <= data_s1.val[m];
					max_q[m] <= data_s1.val[m];
					sum_q[m] <= SUM_W'(data_s1.val[m]);
				end
			end
		end
	end

endmodule

[sv/lws_emit.sv]
// Summary emitter: holds a closed round and sends its four summaries in order.
// Depends on lws_pkg.
module lws_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                snap_load,
	output logic                snap_free,
	input  lws_pkg::summary_t   snap,
	output logic                out_valid,
	input  logic                out_ready,
	output lws_pkg::res_t       out_data
);
	import lws_pkg::*;

	logic                pend_q;
	logic [METRIC_W-1:0] beat_q;
	summary_t            snap_q;
	logic                take;
	logic                last_take;

	assign out_valid = pend_q;
	assign take      = pend_q && out_ready;
	assign last_take = take && (beat_q == MET_FULL);
	assign snap_free = !pend_q || last_take;

	// present the current metric of the held round
	always_comb begin
		out_data.metric       = beat_q;
		out_data.round_number = snap_q.round_number;
		out_data.sample_count = snap_q.count;
		out_data.minimum      = snap_q.min[beat_q];
		out_data.maximum      = snap_q.max[beat_q];
		out_data.sum          = snap_q.sum[beat_q];
		out_data.last         = (beat_q == MET_FULL);
	end

	// advance through the metrics, reload on a new close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			beat_q <= MET_EXEC;
		end else if (snap_load) begin
			pend_q <= 1'b1;
			beat_q <= MET_EXEC;
		end else if (take) begin
			beat_q <= beat_q + 1'b1;
			if (last_take) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_load) begin
			snap_q <= snap;
		end
	end

endmodule

[sv/windowed_latency_statistics_top.sv]
// Windowed latency statistics monitor, top level.
// Request channel in_valid/in_ready/in_data carries one request record or a flush.
// Result channel out_valid/out_ready/out_data carries per-metric round summaries.
// An APB-style port writes round_duration at byte address 0 (64-bit data).
// Throughput: one request per cycle while no summary is waiting.
// A request that closes a round is registered at the accepting edge and judged in
// the next cycle; its first summary is shown after the emitter registers the round,
// then the four summaries go out at one per cycle while out_ready is high.
// A closing request waits in the input register while the emitter still holds
// the summaries of the previous round; non-closing requests flow regardless.
// When the receiver stalls, the emitter holds the current summary unchanged.
// Reset clears the open-round flag, round index, count and pending summaries and
// sets round_duration to 1000000000 ticks.
// Depends on lws_pkg, lws_ingress, lws_round, lws_emit.
module windowed_latency_statistics_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lws_pkg::req_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lws_pkg::res_t                   out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lws_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lws_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lws_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import lws_pkg::*;

	logic              dur_sel;
	logic [TIME_W-1:0] duration_q;
	logic              valid_s1;
	stage_t            data_s1;
	logic              adv;
	logic              snap_load;
	logic              snap_free;
	summary_t          snap;

	// configuration register
	assign pready  = 1'b1;
	assign dur_sel = (paddr[3] == REG_ROUND_DURATION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= ROUND_DURATION_RESET;
		end else if (psel && penable && pwrite && pready && dur_sel) begin
			duration_q <= pwdata[TIME_W-1:0];
		end
	end

	assign prdata = dur_sel ? APB_DATA_W'(duration_q) : '0;

	lws_ingress u_ingress (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	lws_round u_round (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.data_s1        (data_s1),
		.round_duration (duration_q),
		.snap_free      (snap_free),
		.adv            (adv),
		.snap_load      (snap_load),
		.snap           (snap)
	);

	lws_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_load (snap_load),
		.snap_free (snap_free),
		.snap      (snap),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a close never overwrites summaries still being sent
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		snap_load |-> snap_free)
		else $error("round snapshot loaded over pending summaries");

	// summaries of one round follow in metric order
	a_metric_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_data.last) |=>
		(out_valid && out_data.metric == $past(out_data.metric) + 2'd1))
		else $error("summary metric out of order");

	// a new round's summaries start at the first metric
	a_round_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last) |=>
		(!out_valid || out_data.metric == MET_EXEC))
		else $error("summary sequence did not restart at first metric");

	// the minimum of a round never exceeds its maximum
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.minimum <= out_data.maximum))
		else $error("summary minimum above maximum");

endmodule

[sim/windowed_latency_statistics_checker.sv]
`timescale 1ns / 100ps
// Checker for the windowed latency statistics block: watches the request,
// summary and APB channels, predicts the round summaries and compares them.
// Depends on lws_pkg for the payload types and metric codes.
module windowed_latency_statistics_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  lws_pkg::req_t                  in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  lws_pkg::res_t                  out_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lws_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lws_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             pending
);
	import lws_pkg::*;

	// predicted state of the block
	logic [TIME_W-1:0]  round_len;
	logic               round_open;
	logic [TIME_W-1:0]  round_opened_at;
	logic [ROUND_W-1:0] round_no;
	logic [COUNT_W-1:0] req_count;
	logic [TIME_W-1:0]  metric_lo [NUM_METRICS];
	logic [TIME_W-1:0]  metric_hi [NUM_METRICS];
	logic [SUM_W-1:0]   metric_tot [NUM_METRICS];

	res_t summaries_due [$];

	function automatic logic [TIME_W-1:0] clamp_sub(input logic [TIME_W-1:0] later,
			input logic [TIME_W-1:0] earlier);
		return (later >= earlier) ? later - earlier : '0;
	endfunction

	task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
			input logic [SUM_W-1:0] want);
		$display("%0t checker: %s got %0h want %0h", $time, what, got, want);
		fail_count++;
	endtask

	// fold one request into the open round
	task automatic fold_request(input req_t r);
		logic [TIME_W-1:0] v [NUM_METRICS];
		v[MET_EXEC]    = clamp_sub(r.service_end, r.service_start);
		v[MET_LATENCY] = clamp_sub(r.service_start, r.received_time);
		v[MET_PAYLOAD] = TIME_W'(r.payload_bytes);
		v[MET_FULL]    = clamp_sub(r.service_end, r.received_time);
		for (int m = 0; m < NUM_METRICS; m++) begin
			if (req_count == '0) begin
				metric_lo[m] = v[m];
				metric_hi[m] = v[m];
			end else begin
				if (v[m] < metric_lo[m])
					metric_lo[m] = v[m];
				if (v[m] > metric_hi[m])
					metric_hi[m] = v[m];
			end
			metric_tot[m] = metric_tot[m] + SUM_W'(v[m]);
		end
		// count saturates at all ones
		if (req_count != '1)
			req_count = req_count + 1'b1;
	endtask

	// close the open round: queue one summary per metric, in metric order
	task automatic close_round;
		res_t s;
		if (round_open) begin
			for (int m = 0; m < NUM_METRICS; m++) begin
				s.metric       = METRIC_W'(m);
				s.round_number = round_no;
				s.sample_count = req_count;
				s.minimum      = metric_lo[m];
				s.maximum      = metric_hi[m];
				s.sum          = metric_tot[m];
				s.last         = (s.metric == MET_FULL);
				summaries_due.push_back(s);
			end
			round_open = 1'b0;
			round_no   = round_no + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			round_len       = ROUND_DURATION_RESET;
			round_open      = 1'b0;
			round_opened_at = '0;
			round_no        = '0;
			req_count       = '0;
			for (int m = 0; m < NUM_METRICS; m++) begin
				metric_lo[m]  = '0;
				metric_hi[m]  = '0;
				metric_tot[m] = '0;
			end
			summaries_due.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// register write
			if (psel && penable && pwrite && pready && paddr[3] == REG_ROUND_DURATION)
				round_len = pwdata[TIME_W-1:0];

			// compare a delivered summary with the oldest one due
			if (out_valid && out_ready) begin
				if (summaries_due.size() == 0) begin
					report_mismatch("summary with none due, round", out_data.round_number, '0);
				end else begin
					want = summaries_due.pop_front();
					if (out_data.metric != want.metric)
						report_mismatch("metric", out_data.metric, want.metric);
					if (out_data.round_number != want.round_number)
						report_mismatch("round_number", out_data.round_number, want.round_number);
					if (out_data.sample_count != want.sample_count)
						report_mismatch("sample_count", out_data.sample_count, want.sample_count);
					if (out_data.minimum != want.minimum)
						report_mismatch("minimum", out_data.minimum, want.minimum);
					if (out_data.maximum != want.maximum)
						report_mismatch("maximum", out_data.maximum, want.maximum);
					if (out_data.sum != want.sum)
						report_mismatch("sum", out_data.sum, want.sum);
					if (out_data.last != want.last)
						report_mismatch("last", out_data.last, want.last);
				end
			end

			// predict the summaries an accepted request causes
			if (in_valid && in_ready) begin
				if (in_data.operation == OP_FLUSH) begin
					close_round();
				end else if (round_open && in_data.received_time >= round_opened_at &&
						(in_data.received_time - round_opened_at) < round_len) begin
					fold_request(in_data);
				end else begin
					// outside the round: close it and open a fresh one at this request
					close_round();
					round_open      = 1'b1;
					round_opened_at = in_data.received_time;
					req_count       = '0;
					for (int m = 0; m < NUM_METRICS; m++) begin
						metric_lo[m]  = '0;
						metric_hi[m]  = '0;
						metric_tot[m] = '0;
					end
					fold_request(in_data);
				end
			end

			pending <= summaries_due.size();
		end
	end

endmodule

[sim/tb_windowed_latency_statistics_top.sv]
`timescale 1ns / 100ps
// Testbench top for the windowed latency statistics block: drives requests and
// round_duration writes, paces the receiver, and gives the verdict.
// Depends on lws_pkg, windowed_latency_statistics_top and the checker module.
module tb_windowed_latency_statistics_top;
	import lws_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 68;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	req_t                  in_data  = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	res_t                  out_data;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    fail_count;
	int                    pending;

	// receiver pacing
	logic        hold_req   = 1'b0;
	logic        hold_taken = 1'b0;
	int          hold_left  = 0;
	int          ready_mode = 0;
	int unsigned ready_tick = 0;
	int unsigned cycle_no   = 0;

	// sender's rough idea of the open round
	logic [TIME_W-1:0] round_len_set = ROUND_DURATION_RESET;
	logic [TIME_W-1:0] round_base    = '0;
	logic              round_fresh   = 1'b1;
	int                burst_left    = 0;
	logic              gaps_on       = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	windowed_latency_statistics_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	windowed_latency_statistics_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// stop a hung run
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no == CYCLE_LIMIT) begin
			$display("tb_windowed_latency_statistics_top: done, errors");
			$finish;
		end
	end

	// receiver: switch among four ready patterns, with one long hold-off on demand
	always @(posedge clk) begin
		ready_tick <= ready_tick + 1;
		if (ready_tick % 64 == 0)
			ready_mode <= $urandom_range(0, 3);
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			out_ready  <= 1'b0;
			hold_left  <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else begin
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (ready_tick[1:0] != 2'b00);
			endcase
		end
	end

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	function automatic req_t mk_request(input op_t op, input logic [TIME_W-1:0] rx,
			input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] fin,
			input logic [PAY_W-1:0] pay);
		req_t r;
		r.operation     = op;
		r.received_time = rx;
		r.service_start = st;
		r.service_end   = fin;
		r.payload_bytes = pay;
		return r;
	endfunction

	// offer one request and hold it until accepted
	task automatic push_request(input req_t r);
		in_data  <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// APB write of round_duration: setup phase, then access phase
	task automatic write_round_duration(input logic [TIME_W-1:0] len);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_ROUND_DURATION, 3'b000};
		pwdata  <= APB_DATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		round_len_set = len;
	endtask

	// drop valid, wait for every due summary, then let the pipeline settle
	task automatic drain_summaries;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random request: mostly records inside the round, some past its end or
	// before its start, some flushes and some noise
	task automatic make_request(output req_t r);
		int                pick;
		logic [TIME_W-1:0] rx;
		logic [TIME_W-1:0] st;
		logic [TIME_W-1:0] fin;
		logic [PAY_W-1:0]  pay;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			rx = rand48();
		else if (pick < 12)
			rx = round_fresh ? rand48() : round_base + round_len_set - 1'b1;
		else if (pick < 70)
			rx = round_fresh ? rand48() : round_base + rand48() % round_len_set;
		else if (pick < 84)
			rx = round_base + round_len_set + TIME_W'($urandom_range(0, 3));
		else if (pick < 92)
			rx = round_base - TIME_W'($urandom_range(1, 1000));
		else
			rx = rand48();

		case ($urandom_range(0, 9))
			0: begin
				st  = rand48();
				fin = rand48();
			end
			1: begin
				st  = rx - TIME_W'($urandom_range(0, 500));
				fin = st - TIME_W'($urandom_range(0, 500));
			end
			2: begin
				st  = rx + (rand48() >> $urandom_range(0, 40));
				fin = st + (rand48() >> $urandom_range(0, 40));
			end
			default: begin
				st  = rx + TIME_W'($urandom_range(0, 2000));
				fin = st + TIME_W'($urandom_range(0, 5000));
			end
		endcase

		case ($urandom_range(0, 7))
			0: pay = '0;
			1: pay = '1;
			default: pay = $urandom;
		endcase

		if (pick < 6) begin
			r = mk_request(OP_FLUSH, rx, st, fin, pay);
			round_fresh = 1'b1;
		end else begin
			r = mk_request(OP_RECORD, rx, st, fin, pay);
			if (pick >= 70 || round_fresh) begin
				round_base  = rx;
				round_fresh = 1'b0;
			end
		end
	endtask

	initial begin
		req_t              r;
		logic [TIME_W-1:0] len;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: boundaries of the round, clamped differences, flushes
		write_round_duration(TIME_W'(100));
		push_request(mk_request(OP_FLUSH, '0, '0, '0, '0));
		push_request(mk_request(OP_RECORD, '0, '0, '0, '0));
		push_request(mk_request(OP_RECORD, 10, 5, 3, '1));
		push_request(mk_request(OP_RECORD, 99, 99, TIME_MAX, 1));
		push_request(mk_request(OP_RECORD, 100, 200, 300, 77));
		push_request(mk_request(OP_RECORD, 50, 60, 55, 9));
		push_request(mk_request(OP_RECORD, 149, 149, 149, 3));
		push_request(mk_request(OP_FLUSH, 7, 7, 7, 7));
		push_request(mk_request(OP_FLUSH, '0, '0, '0, '0));
		push_request(mk_request(OP_RECORD, TIME_MAX, TIME_MAX, TIME_MAX, '1));
		push_request(mk_request(OP_RECORD, '0, TIME_MAX, '0, 5));
		push_request(mk_request(OP_RECORD, '0, '0, TIME_MAX, '0));
		push_request(mk_request(OP_RECORD, 99, 150, 120, 1000));
		push_request(mk_request(OP_RECORD, 20, 30, 40, 2));
		push_request(mk_request(OP_RECORD, TIME_MAX - 50, TIME_MAX, '0, '1));
		push_request(mk_request(OP_FLUSH, TIME_MAX, TIME_MAX, TIME_MAX, '1));
		push_request(mk_request(OP_RECORD, 12345, 12400, 13000, 64));
		drain_summaries();

		// random phases, each under its own round length
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: len = TIME_W'(1000);
				1: len = TIME_W'(1);
				2: len = TIME_MAX;
				3: len = TIME_W'($urandom_range(2, 1 << 20));
				4: len = ROUND_DURATION_RESET;
				default: len = TIME_W'(64);
			endcase
			write_round_duration(len);
			round_fresh = 1'b1;
			gaps_on     = (ph != 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// one long receiver hold-off while requests keep coming
				if (ph == 1 && k == 5)
					hold_req <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					if (gaps_on) begin
						in_valid <= 1'b0;
						repeat ($urandom_range(1, 12)) @(posedge clk);
					end
				end
				burst_left--;
				make_request(r);
				push_request(r);
			end
			drain_summaries();
		end

		if (fail_count == 0 && pending == 0)
			$display("tb_windowed_latency_statistics_top: done, clean");
		else
			$display("tb_windowed_latency_statistics_top: done, errors");
		$finish;
	end

endmodule
